// ----- rtl/camera_event_frame_splitter_top_defines.svh -----
// ----------------------------------------------------------------------------
// Camera event frame splitter: assertion macros
// Shared property shorthands for the splitter RTL.
// ----------------------------------------------------------------------------
`ifndef CAMERA_EVENT_FRAME_SPLITTER_TOP_DEFINES_SVH
`define CAMERA_EVENT_FRAME_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication
`define CEFS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CEFS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cefs_pkg.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter package
// Widths, protocol bytes, result record and result builders.
// ----------------------------------------------------------------------------
package cefs_pkg;

	localparam int MAX_CHUNK   = 1024;
	localparam int LEN_W       = 11;
	localparam int WIN_BYTES   = 6;
	localparam int HEAD_BYTES  = 9;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef logic [LEN_W-1:0] len_t;

	// protocol bytes
	localparam logic [7:0] SYNC_IMG  = 8'h5A;
	localparam logic [7:0] ID_CAM    = 8'h79;
	localparam logic [7:0] TYPE_IMG  = 8'h02;
	localparam logic [7:0] TAIL_IMG  = 8'h04;
	localparam logic [7:0] END_PKT   = 8'h5D;
	localparam logic [7:0] SYNC_EVT  = 8'h5B;
	localparam logic [7:0] TYPE_EVT  = 8'h42;
	localparam logic [7:0] TAIL_EVT  = 8'h5F;
	localparam logic [7:0] SYNC_ACK  = 8'h1A;
	localparam logic [7:0] MAX_EVENT = 8'd5;

	typedef enum logic [2:0] {
		KIND_LITE    = 3'd0,
		KIND_PACKET  = 3'd1,
		KIND_IMAGE   = 3'd2,
		KIND_ACK     = 3'd3,
		KIND_INVALID = 3'd4,
		KIND_UNKNOWN = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		MODE_UNDECIDED = 4'b0001,
		MODE_MIXED     = 4'b0010,
		MODE_OTHER     = 4'b0100,
		MODE_MIXED_UNK = 4'b1000
	} mode_t;

	typedef struct packed {
		kind_t       frame_kind;
		logic [7:0]  event_code;
		logic [7:0]  ack_code;
		len_t        packet_length;
		logic [7:0]  image_index;
		logic [7:0]  image_total;
		logic        header_match;
		logic        request_next;
		logic        last_result;
	} res_t;

	// up to two results per item: first is queued ahead of second
	typedef struct packed {
		logic [1:0] num;
		res_t       first;
		res_t       second;
	} push_t;

	function automatic res_t make_plain(kind_t kind, logic [7:0] ev, logic [7:0] ack,
			len_t len);
		res_t r;
		r               = '0;
		r.frame_kind    = kind;
		r.event_code    = ev;
		r.ack_code      = ack;
		r.packet_length = len;
		r.last_result   = 1'b1;
		return r;
	endfunction

	function automatic res_t make_packet(len_t len, logic [7:0] pev, logic [7:0] fev,
			logic [7:0] pidx, logic [7:0] ptot, logic last);
		res_t r;
		logic hm;
		logic full;
		hm              = (pev == fev);
		full            = (len >= len_t'(9));
		r               = '0;
		r.frame_kind    = KIND_PACKET;
		r.event_code    = fev;
		r.packet_length = len;
		r.image_index   = full ? pidx : 8'd0;
		r.image_total   = full ? ptot : 8'd0;
		r.header_match  = hm;
		r.request_next  = hm && full && (pidx != ptot);
		r.last_result   = last;
		return r;
	endfunction

endpackage

// ----- rtl/cefs_in_if.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter input channel
// Received byte plus end-of-chunk flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cefs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       chunk_end;

	modport source (output valid, output rx_byte, output chunk_end, input ready);
	modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

// ----- rtl/cefs_out_if.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter output channel
// One classification / packet report per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cefs_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_kind;
	logic [7:0]  event_code;
	logic [7:0]  ack_code;
	logic [10:0] packet_length;
	logic [7:0]  image_index;
	logic [7:0]  image_total;
	logic        header_match;
	logic        request_next;
	logic        last_result;

	modport source (output valid, output frame_kind, output event_code, output ack_code,
		output packet_length, output image_index, output image_total,
		output header_match, output request_next, output last_result, input ready);
	modport sink (input valid, input frame_kind, input event_code, input ack_code,
		input packet_length, input image_index, input image_total,
		input header_match, input request_next, input last_result, output ready);
endinterface

// ----- rtl/cefs_core.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter core
// Input register, chunk/packet state and single-pass result generation.
// ----------------------------------------------------------------------------
`include "camera_event_frame_splitter_top_defines.svh"

module cefs_core (
	input  logic            clk,
	input  logic            arst_n,
	cefs_in_if.sink         in_ch,
	input  logic            room2,
	output cefs_pkg::push_t push
);

	logic                   vld_s1;
	logic [7:0]             byte_s1;
	logic                   end_s1;
	logic                   adv;

	logic [8*cefs_pkg::WIN_BYTES-1:0] win_q, win_n;
	cefs_pkg::len_t         cnt_q, cnt_n;
	logic [7:0]             head_q [cefs_pkg::HEAD_BYTES];
	logic [7:0]             head_n [cefs_pkg::HEAD_BYTES];
	cefs_pkg::mode_t        mode_q, mode_n;
	logic                   open_q, open_n;
	cefs_pkg::len_t         pc_q, pc_n;
	logic [7:0]             pidx_q, pidx_n;
	logic [7:0]             ptot_q, ptot_n;
	logic [7:0]             fev_q, fev_n;
	logic [7:0]             pev_q, pev_n;

	logic [7:0]             w0, w1, w2, w3, w4, w5;
	logic                   hdr5, hdr6;
	logic                   lite_h, lite_n, img_n, ack_n, full_n;
	logic                   mid_vld;
	cefs_pkg::res_t         mid_res, end_res;

	assign adv         = vld_s1 && room2;
	assign in_ch.ready = !vld_s1 || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.rx_byte;
			end_s1  <= in_ch.chunk_end;
		end
	end

	assign win_n = {win_q[8*cefs_pkg::WIN_BYTES-9:0], byte_s1};
	assign w0    = win_n[7:0];
	assign w1    = win_n[15:8];
	assign w2    = win_n[23:16];
	assign w3    = win_n[31:24];
	assign w4    = win_n[39:32];
	assign w5    = win_n[47:40];

	// 5A 79 02 x 04 ending at the current byte; hdr6 also needs the 5D before it
	assign hdr5 = (w4 == cefs_pkg::SYNC_IMG) && (w3 == cefs_pkg::ID_CAM) &&
		(w2 == cefs_pkg::TYPE_IMG) && (w0 == cefs_pkg::TAIL_IMG);
	assign hdr6 = hdr5 && (w5 == cefs_pkg::END_PKT);

	always_comb begin
		for (int i = 0; i < cefs_pkg::HEAD_BYTES; i++) begin
			head_n[i] = (cnt_q == cefs_pkg::len_t'(i)) ? byte_s1 : head_q[i];
		end
		cnt_n = (cnt_q < cefs_pkg::len_t'(cefs_pkg::MAX_CHUNK)) ? cnt_q + 1'b1 : cnt_q;

		lite_h = (head_n[0] == cefs_pkg::SYNC_EVT) && (head_n[1] == cefs_pkg::ID_CAM) &&
			(head_n[2] == cefs_pkg::TYPE_EVT) && (head_n[4] == cefs_pkg::TAIL_EVT);

		mode_n = mode_q;
		fev_n  = fev_q;
		if (cnt_q == cefs_pkg::len_t'(4)) begin
			mode_n = lite_h ? cefs_pkg::MODE_MIXED : cefs_pkg::MODE_OTHER;
		end
		if (cnt_q == cefs_pkg::len_t'(8)) begin
			fev_n = byte_s1;
			if (mode_n == cefs_pkg::MODE_MIXED && byte_s1 > cefs_pkg::MAX_EVENT) begin
				mode_n = cefs_pkg::MODE_MIXED_UNK;
			end
		end

		open_n  = open_q;
		pc_n    = pc_q;
		pidx_n  = pidx_q;
		ptot_n  = ptot_q;
		pev_n   = pev_q;
		mid_vld = 1'b0;
		mid_res = '0;
		if (cnt_q >= cefs_pkg::len_t'(5)) begin
			if (open_q) begin
				pc_n = (pc_q < cefs_pkg::len_t'(cefs_pkg::MAX_CHUNK)) ? pc_q + 1'b1 : pc_q;
				if (pc_n == cefs_pkg::len_t'(8)) begin
					pidx_n = byte_s1;
				end
				if (pc_n == cefs_pkg::len_t'(9)) begin
					ptot_n = byte_s1;
				end
				if (pc_n >= cefs_pkg::len_t'(6) && hdr6) begin
					// close current packet; the new header's 5 bytes start the next one
					mid_vld = (mode_n == cefs_pkg::MODE_MIXED);
					mid_res = cefs_pkg::make_packet(pc_n - cefs_pkg::len_t'(5), pev_q, fev_n,
						pidx_n, ptot_n, 1'b0);
					pc_n    = cefs_pkg::len_t'(5);
					pev_n   = w1;
					pidx_n  = 8'd0;
					ptot_n  = 8'd0;
				end
			end else if (cnt_q >= cefs_pkg::len_t'(9) && hdr5) begin
				open_n = 1'b1;
				pc_n   = cefs_pkg::len_t'(5);
				pev_n  = w1;
				pidx_n = 8'd0;
				ptot_n = 8'd0;
			end
		end

		// chunk classification on the post-update state
		lite_n = (cnt_n >= cefs_pkg::len_t'(5)) && lite_h;
		img_n  = (cnt_n >= cefs_pkg::len_t'(5)) && (head_n[0] == cefs_pkg::SYNC_IMG) &&
			(head_n[1] == cefs_pkg::ID_CAM) && (head_n[2] == cefs_pkg::TYPE_IMG) &&
			(head_n[4] == cefs_pkg::TAIL_IMG);
		ack_n  = (cnt_n >= cefs_pkg::len_t'(4)) && (head_n[0] == cefs_pkg::SYNC_ACK) &&
			(head_n[2] == cefs_pkg::ID_CAM) && (head_n[3] == cefs_pkg::END_PKT);
		full_n = (cnt_n >= cefs_pkg::len_t'(9));

		if (cnt_n == cefs_pkg::len_t'(5)) begin
			end_res = lite_n ?
				cefs_pkg::make_plain(cefs_pkg::KIND_LITE, head_n[3], 8'd0, cnt_n) :
				cefs_pkg::make_plain(cefs_pkg::KIND_INVALID, 8'd0, 8'd0, cnt_n);
		end else if (lite_n) begin
			if (!full_n) begin
				// mixed chunk too short to carry its event byte
				end_res = cefs_pkg::make_plain(cefs_pkg::KIND_UNKNOWN, 8'd0, 8'd0, cnt_n);
			end else if (head_n[8] > cefs_pkg::MAX_EVENT) begin
				end_res = cefs_pkg::make_plain(cefs_pkg::KIND_UNKNOWN, head_n[8], 8'd0, cnt_n);
			end else if (open_n) begin
				end_res = cefs_pkg::make_packet(pc_n, pev_n, fev_n, pidx_n, ptot_n, 1'b1);
			end else begin
				// known event but no packet header seen
				end_res = cefs_pkg::make_plain(cefs_pkg::KIND_PACKET, 8'd0, 8'd0, '0);
			end
		end else if (img_n) begin
			if (head_n[3] > cefs_pkg::MAX_EVENT) begin
				end_res = cefs_pkg::make_plain(cefs_pkg::KIND_UNKNOWN, head_n[3], 8'd0, cnt_n);
			end else begin
				end_res = cefs_pkg::make_plain(cefs_pkg::KIND_IMAGE, head_n[3], 8'd0, cnt_n);
				end_res.image_index  = full_n ? head_n[7] : 8'd0;
				end_res.image_total  = full_n ? head_n[8] : 8'd0;
				end_res.header_match = 1'b1;
				end_res.request_next = full_n && (head_n[7] != head_n[8]);
			end
		end else if (ack_n) begin
			end_res = cefs_pkg::make_plain(cefs_pkg::KIND_ACK, 8'd0, head_n[1], cnt_n);
		end else begin
			end_res = cefs_pkg::make_plain(cefs_pkg::KIND_INVALID, 8'd0, 8'd0, cnt_n);
		end

		push.first  = mid_vld ? mid_res : end_res;
		push.second = end_res;
		if (!adv) begin
			push.num = 2'd0;
		end else begin
			push.num = {1'b0, mid_vld} + {1'b0, end_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			cnt_q  <= '0;
			mode_q <= cefs_pkg::MODE_UNDECIDED;
			open_q <= 1'b0;
			pc_q   <= '0;
			pidx_q <= '0;
			ptot_q <= '0;
			fev_q  <= '0;
			pev_q  <= '0;
			for (int i = 0; i < cefs_pkg::HEAD_BYTES; i++) begin
				head_q[i] <= '0;
			end
		end else if (adv) begin
			if (end_s1) begin
				win_q  <= '0;
				cnt_q  <= '0;
				mode_q <= cefs_pkg::MODE_UNDECIDED;
				open_q <= 1'b0;
				pc_q   <= '0;
				pidx_q <= '0;
				ptot_q <= '0;
				fev_q  <= '0;
				pev_q  <= '0;
				for (int i = 0; i < cefs_pkg::HEAD_BYTES; i++) begin
					head_q[i] <= '0;
				end
			end else begin
				win_q  <= win_n;
				cnt_q  <= cnt_n;
				mode_q <= mode_n;
				open_q <= open_n;
				pc_q   <= pc_n;
				pidx_q <= pidx_n;
				ptot_q <= ptot_n;
				fev_q  <= fev_n;
				pev_q  <= pev_n;
				for (int i = 0; i < cefs_pkg::HEAD_BYTES; i++) begin
					head_q[i] <= head_n[i];
				end
			end
		end
	end

	`CEFS_ASSERT_NEXT(a_end_clears, clk, arst_n, adv && end_s1, cnt_q == '0 && !open_q, "chunk state not cleared after chunk end")
	`CEFS_ASSERT_NOW(a_open_after_head, clk, arst_n, open_q, cnt_q >= cefs_pkg::len_t'(10), "packet open inside chunk head")
	`CEFS_ASSERT_NOW(a_mid_needs_open, clk, arst_n, mid_vld, open_q && mode_n == cefs_pkg::MODE_MIXED, "packet report without open packet")

endmodule

// ----- rtl/cefs_queue.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter result queue
// Four-entry queue taking up to two results per cycle while room2 is high, one out per cycle.
// ----------------------------------------------------------------------------
`include "camera_event_frame_splitter_top_defines.svh"

module cefs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  cefs_pkg::push_t push,
	output logic            room2,
	cefs_out_if.source      out_ch
);

	cefs_pkg::res_t                q_mem [cefs_pkg::QUEUE_DEPTH];
	logic [cefs_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_nxt;
	logic [cefs_pkg::QCNT_W-1:0]   count_q;
	logic                          pop;
	cefs_pkg::res_t                head;

	assign pop    = out_ch.valid && out_ch.ready;
	assign wr_nxt = wr_ptr_q + cefs_pkg::QPTR_W'(1);
	assign room2  = count_q <= cefs_pkg::QCNT_W'(cefs_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			q_mem[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			q_mem[wr_nxt] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cefs_pkg::QPTR_W'(push.num);
			rd_ptr_q <= rd_ptr_q + cefs_pkg::QPTR_W'(pop);
			count_q  <= count_q + cefs_pkg::QCNT_W'(push.num) - cefs_pkg::QCNT_W'(pop);
		end
	end

	assign head                 = q_mem[rd_ptr_q];
	assign out_ch.valid         = count_q != '0;
	assign out_ch.frame_kind    = head.frame_kind;
	assign out_ch.event_code    = head.event_code;
	assign out_ch.ack_code      = head.ack_code;
	assign out_ch.packet_length = head.packet_length;
	assign out_ch.image_index   = head.image_index;
	assign out_ch.image_total   = head.image_total;
	assign out_ch.header_match  = head.header_match;
	assign out_ch.request_next  = head.request_next;
	assign out_ch.last_result   = head.last_result;

	`CEFS_ASSERT_NOW(a_no_overflow, clk, arst_n, push.num != 2'd0, room2, "result queue written without room")
	`CEFS_ASSERT_NEXT(a_pop_count, clk, arst_n, pop && push.num == 2'd0, count_q == $past(count_q) - 1'b1, "queue count off after pop")
	`CEFS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= cefs_pkg::QCNT_W'(cefs_pkg::QUEUE_DEPTH), "queue count above depth")

endmodule

// ----- rtl/camera_event_frame_splitter_top.sv -----
// ----------------------------------------------------------------------------
// Camera event frame splitter
// Classifies receive chunks and splits mixed event/image chunks into packets.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    rx_byte, chunk_end
//   out_ch   out  valid/ready    frame_kind .. last_result (one report each)
//
// One byte accepted per cycle while the input is not stalled. A byte is
// registered, processed from that register, and its reports are written
// into a four-entry queue; a byte yields zero, one or two reports. Input
// stalls only while the queue holds more than two reports.
// Reset is asynchronous and clears all chunk state; no clearing pass.
// ----------------------------------------------------------------------------
module camera_event_frame_splitter_top (
	input  logic       clk,
	input  logic       arst_n,
	cefs_in_if.sink    in_ch,
	cefs_out_if.source out_ch
);

	cefs_pkg::push_t push;
	logic            room2;

	cefs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.room2  (room2),
		.push   (push)
	);

	cefs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.out_ch (out_ch)
	);

endmodule
